// ----- rtl/lps_pkg.sv -----
// Shared types and constants of the LED pattern sequencer.
`default_nettype none
package lps_pkg;

   localparam int MAX_PATTERNS = 16;
   localparam int MAX_STEPS    = 16;
   localparam int LED_WIDTH    = 8;

   localparam int PAT_W   = 4;
   localparam int STEP_W  = 4;
   localparam int REQ_W   = 8;
   localparam int DELAY_W = 16;
   localparam int GRAD_W  = 8;
   localparam int LEN_W   = 5;
   localparam int CNT_W   = 5;
   localparam int PROD_W  = DELAY_W + GRAD_W;
   localparam int MASK_AW = PAT_W + STEP_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_AW     = 3;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_HDR  = 2'd2;

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(10);
   localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_PATTERNS);
   localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(MAX_STEPS);
   localparam logic [GRAD_W-1:0] GRAD_DIM   = GRAD_W'(3);

   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [GRAD_W-1:0]  grad;
      logic [DELAY_W-1:0] delay;
   } hdr_type;

endpackage
`default_nettype wire

// ----- rtl/lps_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module lps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/led_pattern_sequencer_pwm_unit.sv -----
// LED pattern sequencer top level: request decode, header and step-mask memories, duty divider.
//
// Items arrive on the req_ channel; req_tuser carries the action. A step-word load or a
// header load is written into its memory at the transfer edge and gives no result; the
// block is ready again in the next cycle. A tick reads the active pattern's header, updates
// step and elapsed time, reads the step mask and divides elapsed*gradient by the delay in an
// iterative unit that retires one quotient bit per cycle. A tick passes through the header
// read, multiply, divide and output states before its result is loaded into the rsp_ output
// register, and the next item is taken once the block is back in idle. One tick is
// processed at a time.
// The output register lets a new item be taken while a result waits. If the receiver stalls
// and a second tick finishes, that tick waits until the pending result has been transferred.
// Reset clears the pattern, step, elapsed and PWM counters and sets pattern_count to 10. The
// memories are not cleared: every pattern used must be loaded before the first tick.
// csr_ addresses 0-3 write pattern_count; the user writes it only while idle (not enforced).
`default_nettype none
module led_pattern_sequencer_pwm_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // requested_pattern, pattern_slot, step_slot, step_value, delay_ms, gradient_steps,
   // pattern_length, zero padding
   input  wire logic [lps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action
   input  wire logic [1:0]                         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // led_value, active_pattern, step_index
   output logic      [lps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lps_pkg::CSR_AW-1:0]         csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready
);

   import lps_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HDR  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PAT_W-1:0]     pat_ff, pat_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DELAY_W-1:0]   elapsed_ff, elapsed_in;
   logic [GRAD_W-1:0]    pwm_ff, pwm_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [GRAD_W-1:0]    grad_ff, grad_in;
   logic [LED_WIDTH-1:0] mask_ff, mask_in;
   logic [DELAY_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [REQ_W-1:0]   f_req;
   logic [PAT_W-1:0]   f_pslot;
   logic [STEP_W-1:0]  f_sslot;
   logic [LED_WIDTH-1:0] f_value;
   hdr_type            f_hdr;

   logic               req_xfer;
   logic               mask_we, hdr_we, hdr_re, mask_re;
   logic [PAT_W-1:0]   hdr_raddr;
   logic [MASK_AW-1:0] mask_raddr;
   hdr_type            hdr_rdata;
   logic [LED_WIDTH-1:0] mask_rdata;

   logic [CNT_W-1:0]   count_eff;
   logic               req_ok;
   logic [LEN_W-1:0]   len_eff;
   logic               adv;
   logic [LEN_W-1:0]   step_inc;
   logic [STEP_W-1:0]  step_nxt;
   logic [DELAY_W:0]   trial;
   logic               trial_ge;
   logic [GRAD_W-1:0]  duty;
   logic [LED_WIDTH-1:0] led;
   logic [GRAD_W-1:0]  pwm_inc;
   logic               out_free;
   logic               csr_wr;

   assign f_req     = req_tdata[7:0];
   assign f_pslot   = req_tdata[11:8];
   assign f_sslot   = req_tdata[15:12];
   assign f_value   = req_tdata[23:16];
   assign f_hdr.delay = req_tdata[39:24];
   assign f_hdr.grad  = req_tdata[47:40];
   assign f_hdr.len   = req_tdata[52:48];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign mask_we    = req_xfer && (req_tuser == ACT_STEP);
   assign hdr_we     = req_xfer && (req_tuser == ACT_HDR);
   assign hdr_re     = req_xfer && (req_tuser == ACT_TICK);
   assign mask_re    = (state_ff == S_HDR);

   lps_ram #(
      .WIDTH ($bits(hdr_type)),
      .DEPTH (MAX_PATTERNS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (f_pslot),
      .wr_data (f_hdr),
      .rd_en   (hdr_re),
      .rd_addr (hdr_raddr),
      .rd_data (hdr_rdata)
   );

   lps_ram #(
      .WIDTH (LED_WIDTH),
      .DEPTH (MAX_PATTERNS * MAX_STEPS)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr ({f_pslot, f_sslot}),
      .wr_data (f_value),
      .rd_en   (mask_re),
      .rd_addr (mask_raddr),
      .rd_data (mask_rdata)
   );

   assign count_eff = (count_ff > COUNT_MAX) ? COUNT_MAX : count_ff;
   assign req_ok    = (f_req == '0) ||
                      ((f_req > REQ_W'(pat_ff)) && (f_req < REQ_W'(count_eff)));
   assign hdr_raddr = req_ok ? f_req[PAT_W-1:0] : pat_ff;

   assign len_eff  = (hdr_rdata.len > LEN_MAX) ? LEN_MAX : hdr_rdata.len;
   assign adv      = (elapsed_ff == hdr_rdata.delay);
   assign step_inc = adv ? (LEN_W'(step_ff) + LEN_W'(1)) : LEN_W'(step_ff);
   assign step_nxt = (step_inc >= len_eff) ? '0 : step_inc[STEP_W-1:0];
   assign mask_raddr = {pat_ff, step_nxt};

   assign trial    = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_ge = (trial >= {1'b0, delay_ff});

   assign duty    = (delay_ff == '0) ? '0 : quo_ff[GRAD_W-1:0];
   assign led     = (pwm_ff < duty) ? ((grad_ff <= GRAD_DIM) ? '0 : ~mask_ff) : mask_ff;
   assign pwm_inc = pwm_ff + GRAD_W'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pat_in       = pat_ff;
      step_in      = step_ff;
      elapsed_in   = elapsed_ff;
      pwm_in       = pwm_ff;
      delay_in     = delay_ff;
      grad_in      = grad_ff;
      mask_in      = mask_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr && (csr_paddr[2] == 1'b0)) begin
         count_in = csr_pwdata[CNT_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (hdr_re) begin
               if (req_ok) begin
                  pat_in     = f_req[PAT_W-1:0];
                  step_in    = '0;
                  elapsed_in = '0;
               end
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            step_in  = step_nxt;
            if (adv) begin
               elapsed_in = '0;
            end
            delay_in = hdr_rdata.delay;
            grad_in  = hdr_rdata.grad;
            state_in = S_MUL;
         end
         S_MUL: begin
            mask_in    = mask_rdata;
            quo_in     = {{(PROD_W - DELAY_W){1'b0}}, elapsed_ff} *
                         {{(PROD_W - GRAD_W){1'b0}}, grad_ff};
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            rem_in     = trial_ge ? DELAY_W'(trial - {1'b0, delay_ff}) : trial[DELAY_W-1:0];
            quo_in     = {quo_ff[PROD_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(PROD_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {step_ff, pat_ff, led};
               pwm_in       = (pwm_inc >= grad_ff) ? '0 : pwm_inc;
               elapsed_in   = elapsed_ff + DELAY_W'(1);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= COUNT_RESET;
         pat_ff       <= '0;
         step_ff      <= '0;
         elapsed_ff   <= '0;
         pwm_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pat_ff       <= pat_in;
         step_ff      <= step_in;
         elapsed_ff   <= elapsed_in;
         pwm_ff       <= pwm_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff    <= delay_in;
      grad_ff     <= grad_in;
      mask_ff     <= mask_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {{(32 - CNT_W){1'b0}}, count_ff} : '0;

   a_tick_reads_header: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tuser == ACT_TICK) |=> state_ff == S_HDR)
      else $error("tick transfer did not start a header read");

   a_div_count_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_cnt_ff < DIV_CNT_W'(PROD_W))
      else $error("divider ran past its last quotient bit");

   a_result_from_output_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result appeared outside the output state");

   a_load_keeps_counters: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tuser != ACT_TICK) |=> $stable(elapsed_ff) && $stable(pwm_ff))
      else $error("memory load disturbed the tick counters");

endmodule
`default_nettype wire
